>>> hdl/srit_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the segment versus rectangle hit test.
// No dependencies; imported by the top level and the divider step.
package srit_pkg;

    // Default width of every coordinate (signed Q16.16 at 32 bits).
    localparam int COORD_BITS_DEF = 32;

endpackage

>>> hdl/srit_div_step.sv
`timescale 1ns / 1ps
// One registered step of the restoring divider, two lanes side by side.
// Depends on srit_pkg for the default coordinate width.
module srit_div_step
    import srit_pkg::*;
#(
    parameter int W  = COORD_BITS_DEF,
    parameter int CW = 1
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  d_i,
    input  logic [W-1:0]  rem_lo_i,
    input  logic [W-1:0]  lq_lo_i,
    input  logic [W-1:0]  rem_hi_i,
    input  logic [W-1:0]  lq_hi_i,
    input  logic [CW-1:0] ctx_i,
    output logic [W-1:0]  d_o,
    output logic [W-1:0]  rem_lo_o,
    output logic [W-1:0]  lq_lo_o,
    output logic [W-1:0]  rem_hi_o,
    output logic [W-1:0]  lq_hi_o,
    output logic [CW-1:0] ctx_o
);

    logic [W:0]    r2_lo;
    logic [W:0]    r2_hi;
    logic          ge_lo;
    logic          ge_hi;
    logic [W:0]    diff_lo;
    logic [W:0]    diff_hi;
    logic [W-1:0]  rem_lo_next;
    logic [W-1:0]  rem_hi_next;
    logic [W-1:0]  lq_lo_next;
    logic [W-1:0]  lq_hi_next;
    logic [W-1:0]  d_reg;
    logic [W-1:0]  rem_lo_reg;
    logic [W-1:0]  lq_lo_reg;
    logic [W-1:0]  rem_hi_reg;
    logic [W-1:0]  lq_hi_reg;
    logic [CW-1:0] ctx_reg;

    // Bring down the next dividend bit, then subtract the divisor if it fits.
    // The remainder stays below the divisor, so it always fits in W bits.
    always_comb
    begin
        r2_lo       = {rem_lo_i, lq_lo_i[W-1]};
        r2_hi       = {rem_hi_i, lq_hi_i[W-1]};
        diff_lo     = r2_lo - {1'b0, d_i};
        diff_hi     = r2_hi - {1'b0, d_i};
        ge_lo       = (r2_lo >= {1'b0, d_i});
        ge_hi       = (r2_hi >= {1'b0, d_i});
        rem_lo_next = ge_lo ? diff_lo[W-1:0] : r2_lo[W-1:0];
        rem_hi_next = ge_hi ? diff_hi[W-1:0] : r2_hi[W-1:0];
        lq_lo_next  = {lq_lo_i[W-2:0], ge_lo};
        lq_hi_next  = {lq_hi_i[W-2:0], ge_hi};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg      <= d_i;
            rem_lo_reg <= rem_lo_next;
            lq_lo_reg  <= lq_lo_next;
            rem_hi_reg <= rem_hi_next;
            lq_hi_reg  <= lq_hi_next;
            ctx_reg    <= ctx_i;
        end
    end

    assign d_o      = d_reg;
    assign rem_lo_o = rem_lo_reg;
    assign lq_lo_o  = lq_lo_reg;
    assign rem_hi_o = rem_hi_reg;
    assign lq_hi_o  = lq_hi_reg;
    assign ctx_o    = ctx_reg;

endmodule

>>> hdl/segment_rect_intersect_test.sv
`timescale 1ns / 1ps
// Segment versus axis-aligned rectangle hit test, fully pipelined.
// Depends on srit_pkg and srit_div_step.
//
// Usage: each input word carries a rectangle (rect_left, rect_top, rect_right,
// rect_bottom) and a segment (start_x, start_y, end_x, end_y), all signed
// Q16.16 values COORD_BITS wide. Every word yields exactly one output word,
// the single bit hit, in the order the inputs were accepted. Both channels
// use valid and ready; a word moves when both are high at a rising edge.
// A word passes through every pipeline stage and then the output register
// before hit appears. Throughput is one word per cycle while the skid
// register is empty; the divider resolves one quotient bit per pipeline
// stage for both clipped x positions at once.
// Reset is asynchronous and active low; it empties the pipeline and the
// output, and in_ready is high right after reset.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps advancing until one more result lands in a skid register.
// Only then does in_ready drop; it comes back the cycle after the receiver
// takes a word. No word is lost or repeated across a stall.
module segment_rect_intersect_test
    import srit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] rect_left,
    input  logic signed [COORD_BITS-1:0] rect_top,
    input  logic signed [COORD_BITS-1:0] rect_right,
    input  logic signed [COORD_BITS-1:0] rect_bottom,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit
);

    localparam int CB   = COORD_BITS;
    localparam int BLO  = COORD_BITS / 2;
    localparam int BHI  = COORD_BITS - BLO;
    // Five front stages, one stage per quotient bit, two back stages.
    localparam int NSTG = COORD_BITS + 7;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] by;
        logic signed [CB-1:0] top;
        logic signed [CB-1:0] bot;
        logic                 neg_lo;
        logic                 neg_hi;
        logic                 miss;
        logic                 vert;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    // Global advance: the whole pipeline moves unless the skid register is full.
    logic            adv;
    logic            skid_valid_reg;
    logic [NSTG-1:0] vld_reg;

    assign adv      = ~skid_valid_reg;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Stage 1: order the segment's x extent and clip it to the rectangle.
    // The endpoint differences are formed one bit wider so they never wrap.
    logic                 swap_x;
    logic signed [CB-1:0] xmin;
    logic signed [CB-1:0] xmax;
    logic signed [CB-1:0] lox1_next;
    logic signed [CB-1:0] hix1_next;
    logic signed [CB:0]   dx1_next;
    logic signed [CB:0]   dy1_next;
    logic signed [CB-1:0] lox1_reg;
    logic signed [CB-1:0] hix1_reg;
    logic signed [CB-1:0] ax1_reg;
    logic signed [CB-1:0] ay1_reg;
    logic signed [CB-1:0] by1_reg;
    logic signed [CB-1:0] top1_reg;
    logic signed [CB-1:0] bot1_reg;
    logic signed [CB:0]   dx1_reg;
    logic signed [CB:0]   dy1_reg;

    always_comb
    begin
        swap_x    = (start_x > end_x);
        xmin      = swap_x ? end_x : start_x;
        xmax      = swap_x ? start_x : end_x;
        lox1_next = (xmin < rect_left) ? rect_left : xmin;
        hix1_next = (xmax > rect_right) ? rect_right : xmax;
        dx1_next  = (CB+1)'(end_x) - (CB+1)'(start_x);
        dy1_next  = (CB+1)'(end_y) - (CB+1)'(start_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lox1_reg <= lox1_next;
            hix1_reg <= hix1_next;
            ax1_reg  <= start_x;
            ay1_reg  <= start_y;
            by1_reg  <= end_y;
            top1_reg <= rect_top;
            bot1_reg <= rect_bottom;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
        end
    end

    // Stage 2: offsets of the clipped x ends from the start point, the empty
    // x range test, and divisor and slope magnitudes. A clipped x of a non-empty
    // range lies in the segment's extent, so every magnitude fits in CB unsigned bits.
    logic signed [CB:0]   numlo2_next;
    logic signed [CB:0]   numhi2_next;
    logic [CB-1:0]        d2_next;
    logic [CB-1:0]        b2_next;
    logic signed [CB:0]   numlo2_reg;
    logic signed [CB:0]   numhi2_reg;
    logic [CB-1:0]        d2_reg;
    logic [CB-1:0]        b2_reg;
    logic                 sgn2_reg;
    logic                 miss2_reg;
    logic                 vert2_reg;
    logic signed [CB-1:0] ay2_reg;
    logic signed [CB-1:0] by2_reg;
    logic signed [CB-1:0] top2_reg;
    logic signed [CB-1:0] bot2_reg;

    always_comb
    begin
        numlo2_next = (CB+1)'(lox1_reg) - (CB+1)'(ax1_reg);
        numhi2_next = (CB+1)'(hix1_reg) - (CB+1)'(ax1_reg);
        d2_next     = dx1_reg[CB] ? CB'(-dx1_reg) : CB'(dx1_reg);
        b2_next     = dy1_reg[CB] ? CB'(-dy1_reg) : CB'(dy1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numlo2_reg <= numlo2_next;
            numhi2_reg <= numhi2_next;
            d2_reg     <= d2_next;
            b2_reg     <= b2_next;
            sgn2_reg   <= dx1_reg[CB] ^ dy1_reg[CB];
            miss2_reg  <= (lox1_reg > hix1_reg);
            vert2_reg  <= (dx1_reg == '0);
            ay2_reg    <= ay1_reg;
            by2_reg    <= by1_reg;
            top2_reg   <= top1_reg;
            bot2_reg   <= bot1_reg;
        end
    end

    // Stage 3: offset magnitudes and the sign of each interpolated step.
    logic [CB-1:0] alo3_next;
    logic [CB-1:0] ahi3_next;
    ctx_t          c3_next;
    logic [CB-1:0] alo3_reg;
    logic [CB-1:0] ahi3_reg;
    logic [CB-1:0] b3_reg;
    logic [CB-1:0] d3_reg;
    ctx_t          c3_reg;

    always_comb
    begin
        alo3_next      = numlo2_reg[CB] ? CB'(-numlo2_reg) : CB'(numlo2_reg);
        ahi3_next      = numhi2_reg[CB] ? CB'(-numhi2_reg) : CB'(numhi2_reg);
        c3_next.ay     = ay2_reg;
        c3_next.by     = by2_reg;
        c3_next.top    = top2_reg;
        c3_next.bot    = bot2_reg;
        c3_next.neg_lo = numlo2_reg[CB] ^ sgn2_reg;
        c3_next.neg_hi = numhi2_reg[CB] ^ sgn2_reg;
        c3_next.miss   = miss2_reg;
        c3_next.vert   = vert2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alo3_reg <= alo3_next;
            ahi3_reg <= ahi3_next;
            b3_reg   <= b2_reg;
            d3_reg   <= d2_reg;
            c3_reg   <= c3_next;
        end
    end

    // Stage 4: the products are split on the slope magnitude into two
    // half-width partial products per lane.
    logic [CB+BLO-1:0] ppll4_reg;
    logic [CB+BHI-1:0] pplh4_reg;
    logic [CB+BLO-1:0] pphl4_reg;
    logic [CB+BHI-1:0] pphh4_reg;
    logic [CB-1:0]     d4_reg;
    ctx_t              c4_reg;
    ctx_t              c4_reg_in;

    assign c4_reg_in = c3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ppll4_reg <= alo3_reg * b3_reg[BLO-1:0];
            pplh4_reg <= alo3_reg * b3_reg[CB-1:BLO];
            pphl4_reg <= ahi3_reg * b3_reg[BLO-1:0];
            pphh4_reg <= ahi3_reg * b3_reg[CB-1:BLO];
            d4_reg    <= d3_reg;
            c4_reg    <= c4_reg_in;
        end
    end

    // Stage 5: full products, loaded into the divider. The product is below
    // the divisor times 2^CB, so the upper half is already a valid remainder.
    logic [2*CB-1:0] plo5_next;
    logic [2*CB-1:0] phi5_next;
    logic [CB-1:0]   remlo5_reg;
    logic [CB-1:0]   lqlo5_reg;
    logic [CB-1:0]   remhi5_reg;
    logic [CB-1:0]   lqhi5_reg;
    logic [CB-1:0]   d5_reg;
    ctx_t            c5_reg;

    always_comb
    begin
        plo5_next = (2*CB)'(ppll4_reg) + ((2*CB)'(pplh4_reg) << BLO);
        phi5_next = (2*CB)'(pphl4_reg) + ((2*CB)'(pphh4_reg) << BLO);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            remlo5_reg <= plo5_next[2*CB-1:CB];
            lqlo5_reg  <= plo5_next[CB-1:0];
            remhi5_reg <= phi5_next[2*CB-1:CB];
            lqhi5_reg  <= phi5_next[CB-1:0];
            d5_reg     <= d4_reg;
            c5_reg     <= c4_reg;
        end
    end

    // Divider: CB steps, one quotient bit each, both lanes together.
    logic [CB-1:0]    d_s      [0:CB];
    logic [CB-1:0]    rem_lo_s [0:CB];
    logic [CB-1:0]    lq_lo_s  [0:CB];
    logic [CB-1:0]    rem_hi_s [0:CB];
    logic [CB-1:0]    lq_hi_s  [0:CB];
    logic [CTX_W-1:0] ctx_s    [0:CB];

    assign d_s[0]      = d5_reg;
    assign rem_lo_s[0] = remlo5_reg;
    assign lq_lo_s[0]  = lqlo5_reg;
    assign rem_hi_s[0] = remhi5_reg;
    assign lq_hi_s[0]  = lqhi5_reg;
    assign ctx_s[0]    = c5_reg;

    for (genvar k = 0; k < CB; k++)
    begin : g_div
        srit_div_step #(
            .W  (CB),
            .CW (CTX_W)
        ) u_step (
            .clk      (clk),
            .en       (adv),
            .d_i      (d_s[k]),
            .rem_lo_i (rem_lo_s[k]),
            .lq_lo_i  (lq_lo_s[k]),
            .rem_hi_i (rem_hi_s[k]),
            .lq_hi_i  (lq_hi_s[k]),
            .ctx_i    (ctx_s[k]),
            .d_o      (d_s[k+1]),
            .rem_lo_o (rem_lo_s[k+1]),
            .lq_lo_o  (lq_lo_s[k+1]),
            .rem_hi_o (rem_hi_s[k+1]),
            .lq_hi_o  (lq_hi_s[k+1]),
            .ctx_o    (ctx_s[k+1])
        );
    end

    // Stage 6: apply the step sign to the truncated quotients. The true y
    // stays between the endpoint y values, so CB-bit arithmetic is exact.
    // A vertical segment uses its raw endpoint y values instead.
    ctx_t                 cq;
    logic signed [CB-1:0] ylo6_next;
    logic signed [CB-1:0] yhi6_next;
    logic signed [CB-1:0] ylo6_reg;
    logic signed [CB-1:0] yhi6_reg;
    logic signed [CB-1:0] top6_reg;
    logic signed [CB-1:0] bot6_reg;
    logic                 miss6_reg;

    always_comb
    begin
        cq = ctx_t'(ctx_s[CB]);
        if (cq.vert)
        begin
            ylo6_next = cq.ay;
            yhi6_next = cq.by;
        end
        else
        begin
            ylo6_next = cq.neg_lo ? (cq.ay - lq_lo_s[CB]) : (cq.ay + lq_lo_s[CB]);
            yhi6_next = cq.neg_hi ? (cq.ay - lq_hi_s[CB]) : (cq.ay + lq_hi_s[CB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ylo6_reg  <= ylo6_next;
            yhi6_reg  <= yhi6_next;
            top6_reg  <= cq.top;
            bot6_reg  <= cq.bot;
            miss6_reg <= cq.miss;
        end
    end

    // Stage 7: a hit needs a non-empty x range and a clipped y range that is
    // non-empty, i.e. the ordered y span overlaps an uninverted rectangle.
    logic                 swap_y;
    logic signed [CB-1:0] ymin;
    logic signed [CB-1:0] ymax;
    logic                 hit7_next;
    logic                 hit7_reg;

    always_comb
    begin
        swap_y    = (ylo6_reg > yhi6_reg);
        ymin      = swap_y ? yhi6_reg : ylo6_reg;
        ymax      = swap_y ? ylo6_reg : yhi6_reg;
        hit7_next = ~miss6_reg & (ymin <= bot6_reg) & (ymax >= top6_reg)
                  & (top6_reg <= bot6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit7_reg <= hit7_next;
        end
    end

    // Output register with one skid entry. A word leaving the last stage goes
    // straight to the output when that is free or being taken, otherwise into
    // the skid register, which then halts the pipeline.
    logic out_valid_reg;
    logic out_valid_next;
    logic hit_reg;
    logic hit_next;
    logic skid_valid_next;
    logic skid_hit_reg;
    logic skid_hit_next;
    logic pop;
    logic arrive;

    always_comb
    begin
        pop             = out_valid_reg & out_ready;
        arrive          = adv & vld_reg[NSTG-1];
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                hit_next        = skid_hit_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                hit_next       = hit7_reg;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_hit_next   = hit7_reg;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        skid_hit_reg <= skid_hit_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

>>> hdl/srit_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the segment versus rectangle hit test.
// Bound to segment_rect_intersect_test; no other dependencies.
module srit_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("output word changed while stalled");

    // Input back-pressure only exists while an output word is waiting.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no output word pending");

    // Back-pressure starts only after the receiver refused a word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready dropped without an output stall");

    // Back-pressure persists until the receiver takes a word.
    a_stall_persist: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready)
        else $error("in_ready returned while output still stalled");

endmodule

bind segment_rect_intersect_test srit_checker u_srit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
);
